### design/dlpd_pkg.sv
// ============================================================================
// dlpd_pkg
// Shared codes for the decimal length prefix deframer: phase codes, byte role
// codes and the number parser substates.
// ============================================================================
package dlpd_pkg;

    localparam int BYTE_W   = 8;
    localparam int ROLE_W   = 2;
    localparam int LEN_W    = 21;
    localparam int OFFSET_W = 20;
    localparam int ACCUM_W  = 20;

    typedef logic [BYTE_W-1:0]          byte_t;
    typedef logic [ROLE_W-1:0]          role_t;
    typedef logic signed [LEN_W-1:0]    length_t;
    typedef logic [OFFSET_W-1:0]        offset_t;
    typedef logic [ACCUM_W-1:0]         accum_t;

    localparam logic [1:0] PH_PREFIX = 2'd0;
    localparam logic [1:0] PH_FIRST  = 2'd1;
    localparam logic [1:0] PH_BODY   = 2'd2;

    localparam role_t ROLE_PREFIX = 2'd0;
    localparam role_t ROLE_FIRST  = 2'd1;
    localparam role_t ROLE_BODY   = 2'd2;

    localparam logic [1:0] SUB_SKIP   = 2'd0;
    localparam logic [1:0] SUB_SIGN   = 2'd1;
    localparam logic [1:0] SUB_DIGITS = 2'd2;
    localparam logic [1:0] SUB_STOP   = 2'd3;

    localparam accum_t MAG_LIMIT = 20'd999999;

    localparam byte_t CHAR_SPACE = 8'd32;
    localparam byte_t CHAR_TAB   = 8'd9;
    localparam byte_t CHAR_CR    = 8'd13;
    localparam byte_t CHAR_PLUS  = 8'd43;
    localparam byte_t CHAR_MINUS = 8'd45;
    localparam byte_t CHAR_ZERO  = 8'd48;
    localparam byte_t CHAR_NINE  = 8'd57;

endpackage

### design/decimal_length_prefix_deframer.sv
// ============================================================================
// decimal_length_prefix_deframer
// Splits a byte stream into frames, each led by an ASCII decimal length
// prefix, and tags every byte with its role in the frame.
// ============================================================================
// The block takes one byte per clock cycle while out_ready does not stall
// the output, and returns one result per byte: each byte passes the input
// register and then the result register. Between them a combinational
// update of the prefix parser (a times-ten accumulator with saturation) and
// the body counters sets the rate of one byte per cycle. Each frame opens with
// PREFIX_CHARS prefix bytes parsed like atoi; the body then takes the decoded
// number of bytes, or exactly one byte when that number is zero or negative.
module decimal_length_prefix_deframer
    import dlpd_pkg::*;
#(
    parameter int PREFIX_CHARS = 6
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [BYTE_W-1:0]          data_byte,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [ROLE_W-1:0]          byte_role,
    output logic                       frame_done,
    output logic                       length_ready,
    output logic signed [LEN_W-1:0]    decoded_length,
    output logic [OFFSET_W-1:0]        body_offset
);

    localparam int CNT_W = (PREFIX_CHARS > 1) ? $clog2(PREFIX_CHARS) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PREFIX_CHARS - 1);

    logic               s1_valid_reg;
    byte_t              s1_byte_reg;

    logic [1:0]         phase_reg, phase_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [1:0]         sub_reg, sub_next;
    logic               neg_reg, neg_next;
    accum_t             accum_reg, accum_next;
    length_t            remain_reg, remain_next;
    offset_t            pos_reg, pos_next;

    logic               out_valid_reg;
    role_t              role_reg, role_next;
    logic               done_reg, done_next;
    logic               ready_reg, ready_next;
    length_t            length_reg, length_next;
    offset_t            offset_reg, offset_next;

    logic               advance;
    logic               is_digit;
    logic               is_space;
    logic [3:0]         digit_val;
    logic [23:0]        accum_sum;
    accum_t             accum_step;
    logic [1:0]         sub_p;
    logic               neg_p;
    accum_t             accum_p;
    length_t            magnitude;
    length_t            remain_dec;

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || advance;

    assign is_digit  = (s1_byte_reg >= CHAR_ZERO) && (s1_byte_reg <= CHAR_NINE);
    assign is_space  = (s1_byte_reg == CHAR_SPACE)
                    || ((s1_byte_reg >= CHAR_TAB) && (s1_byte_reg <= CHAR_CR));
    assign digit_val = 4'(s1_byte_reg - CHAR_ZERO);

    assign accum_sum  = {1'b0, accum_reg, 3'b000} + {3'b000, accum_reg, 1'b0}
                      + {20'd0, digit_val};
    assign accum_step = (accum_sum > {4'd0, MAG_LIMIT}) ? MAG_LIMIT : accum_sum[ACCUM_W-1:0];

    always_comb
    begin
        sub_p   = sub_reg;
        neg_p   = neg_reg;
        accum_p = accum_reg;
        case (sub_reg)
            SUB_SKIP:
            begin
                if (is_space)
                begin
                    sub_p = SUB_SKIP;
                end
                else if (s1_byte_reg == CHAR_PLUS)
                begin
                    sub_p = SUB_SIGN;
                end
                else if (s1_byte_reg == CHAR_MINUS)
                begin
                    sub_p = SUB_SIGN;
                    neg_p = 1'b1;
                end
                else if (is_digit)
                begin
                    sub_p   = SUB_DIGITS;
                    accum_p = {16'd0, digit_val};
                end
                else
                begin
                    sub_p = SUB_STOP;
                end
            end
            SUB_SIGN, SUB_DIGITS:
            begin
                if (is_digit)
                begin
                    sub_p   = SUB_DIGITS;
                    accum_p = accum_step;
                end
                else
                begin
                    sub_p = SUB_STOP;
                end
            end
            default:
            begin
                sub_p = sub_reg;
            end
        endcase
    end

    assign magnitude  = {1'b0, accum_p};
    assign remain_dec = remain_reg - length_t'(1);

    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        sub_next    = sub_reg;
        neg_next    = neg_reg;
        accum_next  = accum_reg;
        remain_next = remain_reg;
        pos_next    = pos_reg;
        role_next   = ROLE_PREFIX;
        done_next   = 1'b0;
        ready_next  = 1'b0;
        length_next = '0;
        offset_next = '0;
        if ((phase_reg == PH_FIRST) || (phase_reg == PH_BODY))
        begin
            role_next   = (phase_reg == PH_FIRST) ? ROLE_FIRST : ROLE_BODY;
            offset_next = pos_reg;
            remain_next = remain_dec;
            pos_next    = pos_reg + offset_t'(1);
            phase_next  = PH_BODY;
            if (remain_dec[LEN_W-1] || (remain_dec == '0))
            begin
                done_next   = 1'b1;
                phase_next  = PH_PREFIX;
                remain_next = '0;
                pos_next    = '0;
                count_next  = '0;
                sub_next    = SUB_SKIP;
                neg_next    = 1'b0;
                accum_next  = '0;
            end
        end
        else
        begin
            phase_next = PH_PREFIX;
            sub_next   = sub_p;
            neg_next   = neg_p;
            accum_next = accum_p;
            count_next = count_reg + CNT_W'(1);
            if (count_reg == CNT_LAST)
            begin
                length_next = neg_p ? -magnitude : magnitude;
                ready_next  = 1'b1;
                remain_next = neg_p ? -magnitude : magnitude;
                pos_next    = '0;
                phase_next  = PH_FIRST;
                count_next  = '0;
                sub_next    = SUB_SKIP;
                neg_next    = 1'b0;
                accum_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_PREFIX;
            count_reg     <= '0;
            sub_reg       <= SUB_SKIP;
            neg_reg       <= 1'b0;
            accum_reg     <= '0;
            remain_reg    <= '0;
            pos_reg       <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
                if (s1_valid_reg)
                begin
                    phase_reg  <= phase_next;
                    count_reg  <= count_next;
                    sub_reg    <= sub_next;
                    neg_reg    <= neg_next;
                    accum_reg  <= accum_next;
                    remain_reg <= remain_next;
                    pos_reg    <= pos_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_byte_reg <= data_byte;
        end
        if (advance && s1_valid_reg)
        begin
            role_reg   <= role_next;
            done_reg   <= done_next;
            ready_reg  <= ready_next;
            length_reg <= length_next;
            offset_reg <= offset_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign byte_role      = role_reg;
    assign frame_done     = done_reg;
    assign length_ready   = ready_reg;
    assign decoded_length = length_reg;
    assign body_offset    = offset_reg;

    // A finished frame is always closed by a body byte, first or later, never by a prefix byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done |-> byte_role != ROLE_PREFIX)
        else $error("frame_done on a prefix byte");

    // The decoded length is only shown on the last prefix byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !length_ready |-> decoded_length == '0)
        else $error("decoded_length nonzero without length_ready");

    // Prefix bytes carry no body offset.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && byte_role == ROLE_PREFIX |-> body_offset == '0 && !frame_done)
        else $error("prefix byte with body offset or frame_done");

    // The saturating accumulator never passes its limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        accum_reg <= MAG_LIMIT)
        else $error("accumulator above limit");

    // After a byte that ends a frame the next accepted byte is a prefix byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && s1_valid_reg && done_next |=> phase_reg == PH_PREFIX && count_reg == '0)
        else $error("parser not rearmed after frame end");

endmodule
